@@ hw/rtl/vbop_pkg.sv @@
// ----------------------------------------------------------------------------
// vbop_pkg
// Shared types and constants for the voxel brick occupancy packer.
// ----------------------------------------------------------------------------
package vbop_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BLOCK_CNT_W  = 24;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned MASK_W       = 64;
  localparam int unsigned OCT_W        = 8;
  localparam int unsigned HDR_SHIFT    = 8;
  localparam int unsigned STEP_W       = 3;
  localparam int unsigned CMD_Q_DEPTH  = 4;
  localparam int unsigned CMD_Q_PTR_W  = 2;

  localparam logic [POS_W-1:0] POS_LAST = 6'd63;

  // Kind of an output word.
  localparam logic KIND_VOXEL  = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // Position of a word inside a block record.
  localparam logic [1:0] SLOT_HEADER    = 2'd0;
  localparam logic [1:0] SLOT_MASK_LOW  = 2'd1;
  localparam logic [1:0] SLOT_MASK_HIGH = 2'd2;
  localparam logic [1:0] SLOT_START     = 2'd3;

  typedef struct packed {
    logic              occupied;
    logic [WORD_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    logic              word_kind;
    logic [WORD_W-1:0] data_word;
    logic [1:0]        record_slot;
    logic              last_of_run;
    logic              map_done;
  } out_word_t;

  // One classified sample: which words it causes and their contents.
  typedef struct packed {
    logic              has_voxel;
    logic              has_record;
    logic              done;
    logic [WORD_W-1:0] payload;
    logic [WORD_W-1:0] header;
    logic [MASK_W-1:0] mask;
    logic [WORD_W-1:0] start;
  } cmd_t;

endpackage

@@ hw/rtl/vbop_front.sv @@
// ----------------------------------------------------------------------------
// vbop_front
// Accepts voxel samples, tracks scan position and block masks, and turns
// each sample into a command that names the words it causes.
// ----------------------------------------------------------------------------
module vbop_front #(
  parameter int unsigned BLOCK_INDEX_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [vbop_pkg::BLOCK_CNT_W-1:0]     cfg_data_i,
  input  logic                                 accept_i,
  input  vbop_pkg::in_word_t                   in_word_i,
  output logic                                 cmd_push_o,
  output vbop_pkg::cmd_t                       cmd_o
);
  import vbop_pkg::*;

  logic [BLOCK_CNT_W-1:0] block_count_q;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [BLOCK_CNT_W-1:0] cur_blk_q, cur_blk_d;
  logic [MASK_W-1:0]      mask_q, mask_d, mask_upd;
  logic [OCT_W-1:0]       oct_q, oct_d, oct_upd;
  logic [WORD_W-1:0]      emitted_q, emitted_d, emitted_inc;
  logic [WORD_W-1:0]      start_q, start_d;
  logic [BLOCK_CNT_W:0]   next_blk;
  logic                   block_end;
  logic                   map_end;
  logic [2:0]             oct_idx;
  logic [WORD_W-1:0]      blk_field;

  assign block_end   = (pos_q == POS_LAST);
  assign oct_idx     = {pos_q[5], pos_q[3], pos_q[1]};
  assign mask_upd    = mask_q | (in_word_i.occupied ? (MASK_W'(1) << pos_q) : '0);
  assign oct_upd     = oct_q | (in_word_i.occupied ? (OCT_W'(1) << oct_idx) : '0);
  assign emitted_inc = emitted_q + WORD_W'(in_word_i.occupied);
  assign next_blk    = {1'b0, cur_blk_q} + (BLOCK_CNT_W+1)'(1);
  assign map_end     = (next_blk >= {1'b0, block_count_q});
  assign blk_field   = WORD_W'(cur_blk_q[BLOCK_INDEX_BITS-1:0]);

  always_comb begin
    pos_d     = pos_q + POS_W'(1);
    cur_blk_d = cur_blk_q;
    mask_d    = mask_upd;
    oct_d     = oct_upd;
    emitted_d = emitted_inc;
    start_d   = start_q;
    if (block_end) begin
      pos_d  = '0;
      mask_d = '0;
      oct_d  = '0;
      if (map_end) begin
        cur_blk_d = '0;
        emitted_d = '0;
        start_d   = '0;
      end else begin
        cur_blk_d = next_blk[BLOCK_CNT_W-1:0];
        start_d   = emitted_inc;
      end
    end
  end

  always_comb begin
    cmd_o.has_voxel  = in_word_i.occupied;
    cmd_o.has_record = block_end && (mask_upd != '0);
    cmd_o.done       = block_end && map_end;
    cmd_o.payload    = in_word_i.payload;
    cmd_o.header     = WORD_W'(oct_upd) | (blk_field << HDR_SHIFT);
    cmd_o.mask       = mask_upd;
    cmd_o.start      = start_q;
  end

  // Samples that cause no word leave only their state update behind.
  assign cmd_push_o = accept_i && (cmd_o.has_voxel || cmd_o.has_record);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BLOCK_CNT_W'(1);
      pos_q         <= '0;
      cur_blk_q     <= '0;
      mask_q        <= '0;
      oct_q         <= '0;
      emitted_q     <= '0;
      start_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        block_count_q <= cfg_data_i;
      end
      if (accept_i) begin
        pos_q     <= pos_d;
        cur_blk_q <= cur_blk_d;
        mask_q    <= mask_d;
        oct_q     <= oct_d;
        emitted_q <= emitted_d;
        start_q   <= start_d;
      end
    end
  end

endmodule

@@ hw/rtl/vbop_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// vbop_cmd_fifo
// Short command queue between the classifier and the word emitter.
// ----------------------------------------------------------------------------
module vbop_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vbop_pkg::cmd_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output vbop_pkg::cmd_t  data_o
);
  import vbop_pkg::*;

  cmd_t                 entries_q [CMD_Q_DEPTH];
  logic [CMD_Q_PTR_W:0] wr_ptr_q, rd_ptr_q;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[CMD_Q_PTR_W] != rd_ptr_q[CMD_Q_PTR_W]) &&
                   (wr_ptr_q[CMD_Q_PTR_W-1:0] == rd_ptr_q[CMD_Q_PTR_W-1:0]);
  assign data_o  = entries_q[rd_ptr_q[CMD_Q_PTR_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      entries_q[wr_ptr_q[CMD_Q_PTR_W-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= wr_ptr_q + (CMD_Q_PTR_W+1)'(1);
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= rd_ptr_q + (CMD_Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

@@ hw/rtl/vbop_back.sv @@
// ----------------------------------------------------------------------------
// vbop_back
// Expands each command into its voxel word and record words, into an output register,
// one per cycle while the consumer keeps popping.
// ----------------------------------------------------------------------------
module vbop_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_empty_i,
  input  vbop_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 pop,
  output logic                 empty,
  output vbop_pkg::out_word_t  out_word_o
);
  import vbop_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] n_words;
  logic [1:0]        slot;
  logic              is_last;
  logic              load;
  logic              out_v_q;
  out_word_t         out_q, word;

  assign n_words = STEP_W'(cmd_i.has_voxel) + (cmd_i.has_record ? STEP_W'(4) : '0);
  assign is_last = (step_q == n_words - STEP_W'(1));
  assign slot    = 2'(step_q - STEP_W'(cmd_i.has_voxel));
  assign load    = !cmd_empty_i && (!out_v_q || pop);
  assign cmd_pop_o = load && is_last;

  always_comb begin
    word.word_kind   = KIND_RECORD;
    word.record_slot = slot;
    word.last_of_run = is_last;
    word.map_done    = cmd_i.done;
    word.data_word   = cmd_i.header;
    if (cmd_i.has_voxel && (step_q == '0)) begin
      word.word_kind   = KIND_VOXEL;
      word.record_slot = SLOT_HEADER;
      word.data_word   = cmd_i.payload;
    end else begin
      case (slot)
        SLOT_HEADER:    word.data_word = cmd_i.header;
        SLOT_MASK_LOW:  word.data_word = cmd_i.mask[WORD_W-1:0];
        SLOT_MASK_HIGH: word.data_word = cmd_i.mask[MASK_W-1:WORD_W];
        SLOT_START:     word.data_word = cmd_i.start;
        default:        word.data_word = cmd_i.header;
      endcase
    end
  end

  assign step_d = is_last ? '0 : step_q + STEP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= step_d;
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= word;
    end
  end

  assign empty      = !out_v_q;
  assign out_word_o = out_q;

endmodule

@@ hw/rtl/voxel_brick_occupancy_packer_unit.sv @@
// A sample's command waits in the command queue, its words in the single output register.
// Throughput: one sample per cycle in when not full, one word per cycle out when popped.
// A sample closing a non-empty block makes up to five words, so the output register paces.
// A four-entry command queue lets the input run ahead while record words drain.
// Reset clears all scan state and the queues, and sets block_count to 1.
// ----------------------------------------------------------------------------
// voxel_brick_occupancy_packer_unit
// Packs 4x4x4 voxel blocks into voxel payload words followed by block
// records holding the octant mask, occupancy mask and start index.
// ----------------------------------------------------------------------------
module voxel_brick_occupancy_packer_unit #(
  parameter int unsigned BLOCK_INDEX_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vbop_pkg::BLOCK_CNT_W-1:0]  cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  vbop_pkg::in_word_t                in_word_i,
  output logic                              empty,
  input  logic                              pop,
  output vbop_pkg::out_word_t               out_word_o
);
  import vbop_pkg::*;

  // The front classifies every sample as it arrives. Samples that cause
  // words become commands; the back turns each command into its words.
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  // A sample is taken whenever the command queue has room, even if it
  // produces no word, so the full flag mirrors the queue.
  assign full = cmd_full;

  vbop_front #(
    .BLOCK_INDEX_BITS(BLOCK_INDEX_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (push && !cmd_full),
    .in_word_i  (in_word_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  vbop_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  // The back walks the head command word by word and releases it from
  // the queue together with its last word.
  vbop_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_word_o  (out_word_o)
  );

endmodule

@@ hw/rtl/vbop_checker.sv @@
// ----------------------------------------------------------------------------
// vbop_checker
// Port-level checks on the word stream of the packer.
// ----------------------------------------------------------------------------
module vbop_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input vbop_pkg::out_word_t  out_word_o
);
  import vbop_pkg::*;

  // A waiting word that is not taken stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("output word changed while stalled");

  // Voxel words always carry slot zero.
  a_voxel_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.word_kind == KIND_VOXEL) |-> (out_word_o.record_slot == SLOT_HEADER))
    else $error("voxel word with nonzero record slot");

  // The start index closes every record and is always the last word of its sample.
  a_start_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.word_kind == KIND_RECORD && out_word_o.record_slot == SLOT_START)
      |-> out_word_o.last_of_run)
    else $error("record start word not marked last");

  // Earlier record words never end a sample's run.
  a_record_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.word_kind == KIND_RECORD && out_word_o.record_slot != SLOT_START)
      |-> !out_word_o.last_of_run)
    else $error("record word marked last before start word");

  // After a taken record word other than the last, the next slot follows.
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_word_o.word_kind == KIND_RECORD &&
     out_word_o.record_slot != SLOT_START) ##1 !empty
      |-> (out_word_o.word_kind == KIND_RECORD &&
           out_word_o.record_slot == $past(out_word_o.record_slot) + 2'd1))
    else $error("record words out of order");

endmodule

bind voxel_brick_occupancy_packer_unit vbop_checker u_vbop_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_word_o (out_word_o)
);
